### src/lavs_pkg.sv
// Package for the linear aim vector solve block: payload structs, cell
// state structs and fixed-point constants. No dependencies.
`default_nettype none
package lavs_pkg;

  // Fractional bits of the input coordinate and speed format.
  localparam int FRAC_BITS = 16;
  // Distances below this many LSB are treated as degenerate.
  localparam int DEGEN_LIMIT = ((1 << FRAC_BITS) + 9999) / 10000;

  // Square root: 34 result bits, one per cell.
  localparam int SQ_STEPS = 34;
  localparam int SQ_REM_W = 36;
  localparam int SQ_RAD_W = 2 * SQ_STEPS;
  localparam int DIST_W   = SQ_STEPS;

  // Division: 63 quotient bits, one per cell.
  localparam int DIV_STEPS = 63;
  localparam int DIV_W     = DIV_STEPS;
  localparam int TIME_W    = 48;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] speed;
  } in_t;

  typedef struct packed {
    logic signed [31:0]  aim_x;
    logic signed [31:0]  aim_y;
    logic signed [31:0]  aim_z;
    logic [DIST_W-1:0]   distance;
    logic [TIME_W-1:0]   flight_time;
    logic signed [31:0]  speed_echo;
    logic                degenerate;
  } out_t;

  // State handed from one square root cell to the next.
  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [DIST_W-1:0]   root;
    logic [SQ_RAD_W-1:0] rad;
  } sqrt_t;

  // State handed from one divider cell to the next; the numerator shifts
  // out at the top while quotient bits shift in at the bottom.
  typedef struct packed {
    logic [DIST_W-1:0] rem;
    logic [DIV_W-1:0]  nq;
    logic [DIST_W-1:0] dvs;
  } div_t;

endpackage
`default_nettype wire

### src/lavs_sqrt_cell.sv
// One restoring square root cell: settles one root bit per clock.
// Depends on lavs_pkg.
`default_nettype none
module lavs_sqrt_cell (
  input  wire logic            clk_i,
  input  wire lavs_pkg::sqrt_t d_i,
  output lavs_pkg::sqrt_t      d_o
);

  localparam int SQ_REM_W = lavs_pkg::SQ_REM_W;

  logic [SQ_REM_W+1:0] cur, trial;
  lavs_pkg::sqrt_t     nxt_d, nxt_q;

  // Bring in the next radicand pair and try the root bit as one.
  always_comb begin
    cur   = {d_i.rem, d_i.rad[lavs_pkg::SQ_RAD_W-1 -: 2]};
    trial = (SQ_REM_W + 2)'({d_i.root, 2'b01});
    nxt_d.rad = d_i.rad << 2;
    if (cur >= trial) begin
      nxt_d.rem  = SQ_REM_W'(cur - trial);
      nxt_d.root = {d_i.root[lavs_pkg::DIST_W-2:0], 1'b1};
    end else begin
      nxt_d.rem  = cur[SQ_REM_W-1:0];
      nxt_d.root = {d_i.root[lavs_pkg::DIST_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q <= nxt_d;
  end

  assign d_o = nxt_q;

endmodule
`default_nettype wire

### src/lavs_div_cell.sv
// One restoring divider cell: settles one quotient bit per clock.
// Depends on lavs_pkg.
`default_nettype none
module lavs_div_cell (
  input  wire logic           clk_i,
  input  wire lavs_pkg::div_t d_i,
  output lavs_pkg::div_t      d_o
);

  logic [lavs_pkg::DIST_W:0] sh;
  logic                      qbit;
  lavs_pkg::div_t            nxt_d, nxt_q;

  // Shift the next numerator bit into the remainder and subtract if it fits.
  always_comb begin
    sh   = {d_i.rem, d_i.nq[lavs_pkg::DIV_W-1]};
    qbit = (sh >= {1'b0, d_i.dvs});
    nxt_d.dvs = d_i.dvs;
    nxt_d.nq  = {d_i.nq[lavs_pkg::DIV_W-2:0], qbit};
    if (qbit) begin
      nxt_d.rem = lavs_pkg::DIST_W'(sh - {1'b0, d_i.dvs});
    end else begin
      nxt_d.rem = sh[lavs_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q <= nxt_d;
  end

  assign d_o = nxt_q;

endmodule
`default_nettype wire

### src/linear_aim_vector_solve.sv
// Top level of the linear aim vector solve block: delta, squares, a chain
// of square root cells and four chains of divider cells.
// Depends on lavs_pkg, lavs_sqrt_cell and lavs_div_cell.
//
// Usage: drive req_i and raise start_i; the request is taken at that clock
// edge because busy_o is always low. A new request may be given in every
// cycle, so the block sustains one solve per clock.
// Each result appears on result_o for exactly one cycle with
// result_valid_o high. The pipeline behind it is the 34-cell square root
// chain (one root bit per cell) and the 63-cell divider chains (one
// quotient bit per cell), plus three input stages, one setup stage and
// the output register. The aim components and the flight time use four
// parallel divider chains.
// Results come out in request order. The receiver cannot stall; it must
// take each result in the cycle it is shown.
// Reset clears the valid line of the pipeline; requests in flight are
// dropped and no result appears until new requests arrive.
`default_nettype none
module linear_aim_vector_solve (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire lavs_pkg::in_t  req_i,
  output logic                result_valid_o,
  output lavs_pkg::out_t      result_o
);

  localparam int F     = lavs_pkg::FRAC_BITS;
  localparam int SQN   = lavs_pkg::SQ_STEPS;
  localparam int DVN   = lavs_pkg::DIV_STEPS;
  localparam int DW    = lavs_pkg::DIST_W;
  localparam int QW    = lavs_pkg::DIV_W;
  localparam int TW    = lavs_pkg::TIME_W;

  // Data that travels beside the arithmetic.
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [31:0]      speed;
    logic [DW-1:0]    dlen;
    logic             degen;
  } side_t;

  logic                     accept;
  logic [2:0][31:0]         t_in, o_in;
  logic signed [32:0]       delta [3];
  side_t                    side1_d;

  logic                     v1_q, v2_q, v3_q, v4_q, strobe_q;
  side_t                    side1_q, side2_q, side3_q, side4_q;
  logic [2:0][63:0]         sq_q;
  logic [65:0]              sum_q;
  logic [SQN-1:0]           vsq_q;
  side_t                    ssq_q [SQN];
  lavs_pkg::sqrt_t          sq_w [SQN+1];
  lavs_pkg::div_t           dv_w [4][DVN+1];
  lavs_pkg::div_t           dv_d [4];
  lavs_pkg::div_t           dv_w_in_q [4];
  logic [DVN-1:0]           vdv_q;
  side_t                    sdv_q [DVN];
  side_t                    side4_d;
  logic [DW-1:0]            root;
  lavs_pkg::out_t           res_d, res_q;
  logic [31:0]              qmag;
  logic                     spd_pos;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Delta vector at 33 bits with magnitude and sign per component.
  assign t_in = {req_i.target_x, req_i.target_y, req_i.target_z};
  assign o_in = {req_i.origin_x, req_i.origin_y, req_i.origin_z};
  always_comb begin
    side1_d = '0;
    side1_d.speed = req_i.speed;
    for (int i = 0; i < 3; i++) begin
      delta[i] = $signed({t_in[2-i][31], t_in[2-i]}) - $signed({o_in[2-i][31], o_in[2-i]});
      side1_d.neg[i] = delta[i][32];
      side1_d.mag[i] = delta[i][32] ? 32'(-delta[i]) : delta[i][31:0];
    end
  end

  // Valid line of the input, square and sum stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Input, square and sum stages.
  always_ff @(posedge clk_i) begin
    side1_q <= side1_d;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= 64'(side1_q.mag[i]) * 64'(side1_q.mag[i]);
    end
    side2_q <= side1_q;
    sum_q   <= 66'(sq_q[0]) + 66'(sq_q[1]) + 66'(sq_q[2]);
    side3_q <= side2_q;
  end

  // Square root chain.
  assign sq_w[0] = '{rem: '0, root: '0, rad: {2'b00, sum_q}};
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    lavs_sqrt_cell u_cell (
      .clk_i (clk_i),
      .d_i   (sq_w[k]),
      .d_o   (sq_w[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsq_q <= '0;
    end else begin
      vsq_q <= {vsq_q[SQN-2:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    ssq_q[0] <= side3_q;
    for (int k = 1; k < SQN; k++) begin
      ssq_q[k] <= ssq_q[k-1];
    end
  end

  // Setup stage: degenerate test and the divider operands.
  assign root    = sq_w[SQN].root;
  assign spd_pos = !ssq_q[SQN-1].speed[31] && (ssq_q[SQN-1].speed != '0);
  always_comb begin
    side4_d       = ssq_q[SQN-1];
    side4_d.dlen  = root;
    side4_d.degen = (root < DW'(lavs_pkg::DEGEN_LIMIT));
    for (int i = 0; i < 3; i++) begin
      dv_d[i].rem = '0;
      dv_d[i].dvs = root;
      dv_d[i].nq  = ({QW'(side4_d.mag[i])} << 30) + QW'(root[DW-1:1]);
    end
    dv_d[3].rem = '0;
    dv_d[3].dvs = spd_pos ? DW'(side4_d.speed[30:0]) : DW'(1);
    dv_d[3].nq  = QW'(root) << F;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= vsq_q[SQN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side4_q <= side4_d;
    for (int c = 0; c < 4; c++) begin
      dv_w_in_q[c] <= dv_d[c];
    end
  end

  // Divider chains: three aim components and the flight time.
  for (genvar c = 0; c < 4; c++) begin : g_chain
    assign dv_w[c][0] = dv_w_in_q[c];
    for (genvar k = 0; k < DVN; k++) begin : g_div
      lavs_div_cell u_cell (
        .clk_i (clk_i),
        .d_i   (dv_w[c][k]),
        .d_o   (dv_w[c][k+1])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdv_q <= '0;
    end else begin
      vdv_q <= {vdv_q[DVN-2:0], v4_q};
    end
  end

  always_ff @(posedge clk_i) begin
    sdv_q[0] <= side4_q;
    for (int k = 1; k < DVN; k++) begin
      sdv_q[k] <= sdv_q[k-1];
    end
  end

  // Result assembly: sign, degenerate override and time saturation.
  always_comb begin
    res_d = '0;
    qmag  = '0;
    for (int i = 0; i < 3; i++) begin
      if (sdv_q[DVN-1].degen) begin
        qmag = sdv_q[DVN-1].mag[i] << (30 - F);
      end else begin
        qmag = dv_w[i][DVN].nq[31:0];
      end
      if (sdv_q[DVN-1].neg[i]) begin
        qmag = -qmag;
      end
      case (i)
        0:       res_d.aim_x = qmag;
        1:       res_d.aim_y = qmag;
        default: res_d.aim_z = qmag;
      endcase
    end
    res_d.degenerate = sdv_q[DVN-1].degen;
    res_d.distance   = sdv_q[DVN-1].degen ? '0 : sdv_q[DVN-1].dlen;
    res_d.speed_echo = sdv_q[DVN-1].speed;
    if (sdv_q[DVN-1].degen || sdv_q[DVN-1].speed[31] || (sdv_q[DVN-1].speed == '0)) begin
      res_d.flight_time = '0;
    end else if (dv_w[3][DVN].nq[QW-1:TW] != '0) begin
      res_d.flight_time = '1;
    end else begin
      res_d.flight_time = dv_w[3][DVN].nq[TW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= vdv_q[DVN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = strobe_q;
  assign result_o       = res_q;

  // A degenerate result carries no distance and no flight time.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.degenerate |->
      (result_o.distance == '0) && (result_o.flight_time == '0))
    else $error("degenerate result with nonzero distance or time");

  // The end of the divider valid line always turns into a strobe.
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vdv_q[DVN-1] |=> result_valid_o)
    else $error("lost result at the output register");

  // A non-positive speed never yields a flight time.
  a_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.speed_echo[31] || (result_o.speed_echo == '0)) |->
      (result_o.flight_time == '0))
    else $error("flight time for non-positive speed");

endmodule
`default_nettype wire
